### design/pcs_pkg.sv
// Shared types, constants and mask functions of the PCI configuration space write block.
package pcs_pkg;

	localparam int SPACE_BYTES = 256;
	localparam int NUM_BARS    = 6;

	localparam int LANES     = 4;
	localparam int ADDR_W    = $clog2(SPACE_BYTES);
	localparam int WORD_W    = ADDR_W - 2;
	localparam int WORDS     = SPACE_BYTES / LANES;
	localparam int BAR_IDX_W = (NUM_BARS > 1) ? $clog2(NUM_BARS) : 1;
	localparam int TYPE_W    = 24;
	localparam int SIZE_W    = 5;
	localparam int IDX_W     = 3;
	localparam int CFG_DATA_W = 24;

	// Register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_ROM   = 3'd6;
	localparam logic [IDX_W-1:0] REG_TYPES = 3'd7;

	// Item opcodes
	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_PRELOAD = 1'b1;

	// Address map
	localparam logic [7:0] BAR_BASE   = 8'h10;
	localparam logic [8:0] BAR_END    = 9'(16 + 4 * NUM_BARS);
	localparam logic [7:0] ROM_BASE   = 8'h30;
	localparam logic [7:0] ROM_END    = 8'h34;
	localparam logic [7:0] CMD_END    = 8'h06;
	localparam logic [8:0] CMD_LO     = 9'h004;
	localparam logic [7:0] HDR_ADDR   = 8'h0e;
	localparam logic [7:0] HDR_MULTI  = 8'h80;
	localparam logic [1:0] HDR_LANE   = HDR_ADDR[1:0];
	localparam logic [WORD_W-1:0] HDR_WORD = HDR_ADDR[ADDR_W-1:2];

	typedef struct packed {
		logic        opcode;
		logic [7:0]  offset;
		logic [31:0] write_data;
		logic [2:0]  byte_count;
	} req_t;

	typedef struct packed {
		logic       remap_needed;
		logic [2:0] bytes_stored;
	} rsp_t;

	typedef struct packed {
		logic [NUM_BARS-1:0][SIZE_W-1:0] bar_size;
		logic [SIZE_W-1:0]               rom_size;
		logic [TYPE_W-1:0]               bar_types;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [WORD_W-1:0] word;
		logic [7:0]        data;
	} lane_wr_t;

	// Bytes shared by both header layouts that a config write may not touch
	function automatic logic locked_common(input logic [8:0] a);
		return (a <= 9'h003) || (a >= 9'h008 && a <= 9'h00b) || (a == 9'h00e) ||
			(a == 9'h03d);
	endfunction

	function automatic logic locked_type0(input logic [8:0] a);
		return locked_common(a) || (a >= 9'h010 && a <= 9'h027) ||
			(a >= 9'h030 && a <= 9'h033);
	endfunction

	function automatic logic locked_type1(input logic [8:0] a);
		return locked_common(a) || (a >= 9'h038 && a <= 9'h03b);
	endfunction

endpackage

### design/pci_config_space_write.sv
// Top level of the PCI configuration space write block.
// Path: an accepted item waits in stage 1 for the header byte, then moves to the result register.
// Throughput: one item per cycle unless rsp_ready stalls; the header byte from lane memory 2 is
//   forwarded from a write in the same cycle, so back-to-back items never wait on the store.
// Reset: clears the configuration registers and the valid flags; the byte store is not cleared.
//   The user must have every entry preloaded before it is read; the block does not enforce this.
module pci_config_space_write (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [pcs_pkg::IDX_W-1:0]      cfg_index,
	input  logic [pcs_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  pcs_pkg::req_t                  req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output pcs_pkg::rsp_t                  rsp
);

	pcs_pkg::cfg_t                          cfg;
	pcs_pkg::req_t                          s1_q;
	logic                                   s1_valid_q;
	logic                                   s1_adv;
	logic                                   accept;
	logic [7:0]                             hdr;
	pcs_pkg::lane_wr_t [pcs_pkg::LANES-1:0] wr_dec;
	pcs_pkg::lane_wr_t [pcs_pkg::LANES-1:0] wr;
	pcs_pkg::rsp_t                          rsp_dec;
	pcs_pkg::rsp_t                          rsp_q;
	logic                                   rsp_valid_q;

	pcs_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.cfg         (cfg)
	);

	// Stage 1 advances into the result register when that register is free or being drained
	assign s1_adv    = s1_valid_q && (!rsp_valid_q || rsp_ready);
	assign req_ready = !s1_valid_q || s1_adv;
	assign accept    = req_valid && req_ready;

	// Hold the item in stage 1 while the header byte comes back from the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q <= req;
		end
	end

	pcs_write_unit u_dec (
		.req (s1_q),
		.hdr (hdr),
		.cfg (cfg),
		.wr  (wr_dec),
		.rsp (rsp_dec)
	);

	// Commit the byte writes only as the item leaves stage 1
	always_comb begin
		wr = wr_dec;
		for (int l = 0; l < pcs_pkg::LANES; l++) begin
			wr[l].en = wr_dec[l].en && s1_adv;
		end
	end

	pcs_store u_store (
		.clk       (clk),
		.wr        (wr),
		.hdr_rd_en (accept),
		.hdr_q     (hdr)
	);

	// Result register: parts the store pipeline from the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q <= rsp_dec;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_adv_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> rsp_valid)
		else $error("stage 1 advanced without a result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.bytes_stored <= 3'd4))
		else $error("byte count above four");

	a_preload_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && (s1_q.opcode == pcs_pkg::OP_PRELOAD)) |=>
			(!rsp.remap_needed && (rsp.bytes_stored <= 3'd1)))
		else $error("preload result out of range");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_adv |-> (wr[0].en == 1'b0 && wr[1].en == 1'b0 && wr[2].en == 1'b0 &&
			wr[3].en == 1'b0))
		else $error("store written without an item leaving stage 1");

endmodule

### design/pcs_cfg_regs.sv
// Configuration register file: region sizes and type codes.
module pcs_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [pcs_pkg::IDX_W-1:0]     cfg_index,
	input  logic [pcs_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	output pcs_pkg::cfg_t                 cfg
);

	pcs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_index < pcs_pkg::IDX_W'(pcs_pkg::NUM_BARS)) begin
				cfg_q.bar_size[cfg_index[pcs_pkg::BAR_IDX_W-1:0]] <=
					cfg_wr_data[pcs_pkg::SIZE_W-1:0];
			end else if (cfg_index == pcs_pkg::REG_ROM) begin
				cfg_q.rom_size <= cfg_wr_data[pcs_pkg::SIZE_W-1:0];
			end else if (cfg_index == pcs_pkg::REG_TYPES) begin
				cfg_q.bar_types <= cfg_wr_data[pcs_pkg::TYPE_W-1:0];
			end
		end
	end

	assign cfg = cfg_q;

endmodule

### design/pcs_store.sv
// Configuration byte store: four byte-lane memories with a header read port.
module pcs_store (
	input  logic                                clk,
	input  pcs_pkg::lane_wr_t [pcs_pkg::LANES-1:0] wr,
	input  logic                                hdr_rd_en,
	output logic [7:0]                          hdr_q
);

	logic [7:0] mem_q [pcs_pkg::LANES][pcs_pkg::WORDS];
	logic       hdr_fwd;

	always_ff @(posedge clk) begin
		for (int l = 0; l < pcs_pkg::LANES; l++) begin
			if (wr[l].en) begin
				mem_q[l][wr[l].word] <= wr[l].data;
			end
		end
	end

	// A write to the header byte in the same cycle wins over the stored value
	assign hdr_fwd = wr[pcs_pkg::HDR_LANE].en &&
		(wr[pcs_pkg::HDR_LANE].word == pcs_pkg::HDR_WORD);

	always_ff @(posedge clk) begin
		if (hdr_rd_en) begin
			hdr_q <= hdr_fwd ? wr[pcs_pkg::HDR_LANE].data
				: mem_q[pcs_pkg::HDR_LANE][pcs_pkg::HDR_WORD];
		end
	end

endmodule

### design/pcs_write_unit.sv
// Write decode: region masking, read-only masking and byte-lane steering.
module pcs_write_unit (
	input  pcs_pkg::req_t                      req,
	input  logic [7:0]                         hdr,
	input  pcs_pkg::cfg_t                      cfg,
	output pcs_pkg::lane_wr_t [pcs_pkg::LANES-1:0] wr,
	output pcs_pkg::rsp_t                      rsp
);

	logic [2:0]                     cnt_sat;
	logic                           bar_hit;
	logic                           rom_hit;
	logic [7:0]                     bar_rel;
	logic [pcs_pkg::BAR_IDX_W-1:0]  slot;
	logic [pcs_pkg::SIZE_W-1:0]     lg;
	logic                           region_take;
	logic [31:0]                    size_mask;
	logic [31:0]                    val_eff;
	logic                           type0;
	logic [1:0]                     idx   [pcs_pkg::LANES];
	logic [8:0]                     addr  [pcs_pkg::LANES];
	logic [pcs_pkg::LANES-1:0]      lane_en;

	assign cnt_sat = (req.byte_count > 3'd4) ? 3'd4 : req.byte_count;
	assign bar_hit = (req.offset >= pcs_pkg::BAR_BASE) && ({1'b0, req.offset} < pcs_pkg::BAR_END);
	assign rom_hit = (req.offset >= pcs_pkg::ROM_BASE) && (req.offset < pcs_pkg::ROM_END);
	assign bar_rel = req.offset - pcs_pkg::BAR_BASE;
	assign slot    = bar_rel[2 +: pcs_pkg::BAR_IDX_W];
	assign lg      = rom_hit ? cfg.rom_size : cfg.bar_size[slot];

	assign region_take = (req.opcode == pcs_pkg::OP_WRITE) && (cnt_sat == 3'd4) &&
		(bar_hit || rom_hit) && (lg != '0);

	assign size_mask = ~((32'd1 << lg) - 32'd1);

	always_comb begin
		if (!region_take) begin
			val_eff = req.write_data;
		end else if (rom_hit) begin
			val_eff = req.write_data & (size_mask | 32'd1);
		end else begin
			val_eff = (req.write_data & size_mask) |
				{28'd0, cfg.bar_types[4 * slot +: 4]};
		end
	end

	assign type0 = (hdr == 8'h00) || (hdr == pcs_pkg::HDR_MULTI);

	// Each lane takes at most one byte of the item
	for (genvar l = 0; l < pcs_pkg::LANES; l++) begin : g_lane
		logic take;
		assign idx[l]  = 2'(l) - req.offset[1:0];
		assign addr[l] = {1'b0, req.offset} + 9'(idx[l]);
		always_comb begin
			if (req.opcode == pcs_pkg::OP_PRELOAD) begin
				take = (idx[l] == 2'd0);
			end else if (region_take) begin
				take = 1'b1;
			end else begin
				take = ({1'b0, idx[l]} < cnt_sat) &&
					!(type0 ? pcs_pkg::locked_type0(addr[l]) : pcs_pkg::locked_type1(addr[l]));
			end
		end
		assign lane_en[l] = take && (addr[l] < 9'(pcs_pkg::SPACE_BYTES));
		assign wr[l].en   = lane_en[l];
		assign wr[l].word = addr[l][pcs_pkg::ADDR_W-1:2];
		assign wr[l].data = val_eff[8 * idx[l] +: 8];
	end

	always_comb begin
		rsp.bytes_stored = 3'(lane_en[0]) + 3'(lane_en[1]) + 3'(lane_en[2]) + 3'(lane_en[3]);
		if (req.opcode == pcs_pkg::OP_PRELOAD) begin
			rsp.remap_needed = 1'b0;
		end else if (region_take) begin
			rsp.remap_needed = 1'b1;
		end else begin
			// Access covers a byte of the command register
			rsp.remap_needed = (cnt_sat != 3'd0) &&
				(({1'b0, req.offset} + 9'(cnt_sat)) > pcs_pkg::CMD_LO) &&
				(req.offset < pcs_pkg::CMD_END);
		end
	end

endmodule

### tb/testbench.sv
// Self-checking testbench for the PCI configuration space write block.
`timescale 1ns / 1ps

module testbench;

	localparam int IDX_W = pcs_pkg::IDX_W;

	// Address map as the predictor sees it
	localparam logic [7:0] BAR_FIRST   = 8'h10;
	localparam logic [7:0] BAR_LAST    = 8'h27;
	localparam logic [7:0] ROM_FIRST   = 8'h30;
	localparam logic [7:0] ROM_LAST    = 8'h33;
	localparam logic [7:0] HEADER_ADDR = 8'h0e;
	localparam logic [7:0] HEADER_MF   = 8'h80;
	localparam logic [8:0] CMD_FIRST   = 9'h004;
	localparam logic [7:0] CMD_LAST    = 8'h05;
	localparam logic [8:0] SPACE_END   = 9'h100;
	localparam int         ROM_SLOT    = 6;
	localparam int         REG_BAR0    = 0;

	// Region sizes for the mixed setting, region 0 in the low bits, ROM in the top bits
	localparam logic [34:0] MIXED_LOG2  = {5'd11, 5'd20, 5'd12, 5'd1, 5'd31, 5'd4, 5'd0};
	localparam logic [23:0] MIXED_TYPES = 24'h5a3c96;

	typedef enum int {SET_MIXED, SET_MAX, SET_ZERO, SET_MIN, SET_RANDOM} setting_e;

	logic clk;
	logic arst_n = 1'b0;

	logic             cfg_wr_en = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [23:0]      cfg_wr_data = '0;

	logic          req_valid = 1'b0;
	logic          req_ready;
	pcs_pkg::req_t req = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	pcs_pkg::rsp_t rsp;

	pci_config_space_write DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp)
	);

	// Mirror of the configuration space and of the register file
	logic [7:0]  space_mirror [0:255];
	logic [4:0]  size_log2 [0:6];
	logic [23:0] type_codes;

	pcs_pkg::req_t pending_accesses [$];
	pcs_pkg::rsp_t predicted_responses [$];

	int            mismatch_count = 0;
	int            gap_left = 0;
	int            stall_left = 0;
	bit            quiet = 1'b0;
	pcs_pkg::rsp_t oldest;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#5000000;
		$display("testbench: FAIL");
		$finish;
	end

	// Read-only bytes of the two header layouts
	function automatic logic byte_locked(input logic [8:0] addr, input logic type0);
		logic common;
		common = (addr <= 9'h003) || (addr >= 9'h008 && addr <= 9'h00b) ||
			(addr == 9'h00e) || (addr == 9'h03d);
		if (type0)
			return common || (addr >= 9'h010 && addr <= 9'h027) ||
				(addr >= 9'h030 && addr <= 9'h033);
		return common || (addr >= 9'h038 && addr <= 9'h03b);
	endfunction

	// Apply one access to the mirror and return the response it must produce
	function automatic pcs_pkg::rsp_t predict_response(input pcs_pkg::req_t item);
		pcs_pkg::rsp_t res;
		logic [31:0]   value;
		logic [31:0]   keep;
		logic [8:0]    addr;
		logic [2:0]    count;
		logic [4:0]    lg;
		logic          is_rom;
		logic          type0;
		int            slot;
		int            stored;
		int            i;
		res    = '0;
		stored = 0;
		value  = item.write_data;
		if (item.opcode == pcs_pkg::OP_PRELOAD) begin
			space_mirror[item.offset] = value[7:0];
			res.bytes_stored = 3'd1;
			return res;
		end
		count = (item.byte_count > 3'd4) ? 3'd4 : item.byte_count;
		// Full-word writes into an implemented BAR or the ROM register bypass the byte mask
		if (count == 3'd4 && ((item.offset >= BAR_FIRST && item.offset <= BAR_LAST) ||
				(item.offset >= ROM_FIRST && item.offset <= ROM_LAST))) begin
			is_rom = item.offset >= ROM_FIRST;
			slot   = is_rom ? ROM_SLOT : int'((item.offset - BAR_FIRST) >> 2);
			lg     = size_log2[slot];
			if (lg != 5'd0) begin
				keep = 32'hffff_ffff << lg;
				if (is_rom)
					value = value & (keep | 32'd1);
				else
					value = (value & keep) | 32'((type_codes >> (4 * slot)) & 24'h00000f);
				for (i = 0; i < 4; i++) begin
					addr = 9'(item.offset) + 9'(i);
					if (addr < SPACE_END) begin
						space_mirror[addr[7:0]] = value[8*i +: 8];
						stored++;
					end
				end
				res.remap_needed = 1'b1;
				res.bytes_stored = 3'(stored);
				return res;
			end
		end
		if (count != 3'd0) begin
			type0 = (space_mirror[HEADER_ADDR] == 8'h00) ||
				(space_mirror[HEADER_ADDR] == HEADER_MF);
			for (i = 0; i < int'(count); i++) begin
				addr = 9'(item.offset) + 9'(i);
				if (!byte_locked(addr, type0) && addr < SPACE_END) begin
					space_mirror[addr[7:0]] = value[8*i +: 8];
					stored++;
				end
			end
			if (9'(item.offset) + 9'(count) > CMD_FIRST && item.offset <= CMD_LAST)
				res.remap_needed = 1'b1;
		end
		res.bytes_stored = 3'(stored);
		return res;
	endfunction

	function automatic pcs_pkg::req_t random_access();
		pcs_pkg::req_t item;
		int            pick;
		item            = '0;
		item.opcode     = pcs_pkg::OP_WRITE;
		item.write_data = $urandom;
		item.byte_count = 3'($urandom_range(1, 4));
		item.offset     = 8'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 10) begin
			// Preload, half of them retargeting the header type
			item.opcode     = pcs_pkg::OP_PRELOAD;
			item.byte_count = 3'($urandom_range(7));
			if ($urandom_range(1) == 0) begin
				item.offset = HEADER_ADDR;
				case ($urandom_range(2))
					0: item.write_data[7:0] = 8'h00;
					1: item.write_data[7:0] = HEADER_MF;
					default: ;
				endcase
			end
		end else if (pick < 45) begin
			// Full-word region writes, sometimes with an oversized count
			item.byte_count = ($urandom_range(7) == 0) ? 3'($urandom_range(5, 7)) : 3'd4;
			item.offset = ($urandom_range(3) == 0) ? 8'($urandom_range(ROM_FIRST, ROM_LAST)) :
				8'($urandom_range(BAR_FIRST, BAR_LAST));
		end else if (pick < 60) begin
			item.offset     = 8'($urandom_range(7));
			item.byte_count = 3'($urandom_range(7));
		end else if (pick < 70) begin
			item.offset     = 8'($urandom_range(8'hf8, 8'hff));
			item.byte_count = 3'($urandom_range(7));
		end else if ($urandom_range(9) == 0) begin
			item.byte_count = 3'($urandom_range(7));
		end else if ($urandom_range(1) == 0) begin
			item.offset = 8'($urandom_range(8'h3f));
		end
		case ($urandom_range(15))
			0: item.write_data = 32'h0000_0000;
			1: item.write_data = 32'hffff_ffff;
			default: ;
		endcase
		return item;
	endfunction

	task automatic queue_write(input logic [7:0] offset, input logic [31:0] data,
			input logic [2:0] count);
		pcs_pkg::req_t item;
		item            = '0;
		item.opcode     = pcs_pkg::OP_WRITE;
		item.offset     = offset;
		item.write_data = data;
		item.byte_count = count;
		pending_accesses.push_back(item);
	endtask

	task automatic queue_preload(input logic [7:0] offset, input logic [31:0] data);
		pcs_pkg::req_t item;
		item            = '0;
		item.opcode     = pcs_pkg::OP_PRELOAD;
		item.offset     = offset;
		item.write_data = data;
		item.byte_count = 3'($urandom_range(7));
		pending_accesses.push_back(item);
	endtask

	// Write all eight registers back to back; the block is idle while this runs
	task automatic apply_settings(input setting_e kind);
		logic [23:0] data;
		int          n;
		for (n = 0; n < 8; n++) begin
			case (kind)
				SET_MIXED:  data = (IDX_W'(n) == pcs_pkg::REG_TYPES) ? MIXED_TYPES :
					24'(MIXED_LOG2[5*n +: 5]);
				SET_MAX:    data = (IDX_W'(n) == pcs_pkg::REG_TYPES) ? 24'hffffff : 24'd31;
				SET_ZERO:   data = 24'd0;
				SET_MIN:    data = (IDX_W'(n) == pcs_pkg::REG_TYPES) ? 24'd0 : 24'd1;
				default:    data = 24'($urandom);
			endcase
			@(posedge clk);
			cfg_wr_en   <= 1'b1;
			cfg_index   <= IDX_W'(REG_BAR0 + n);
			cfg_wr_data <= data;
			if (IDX_W'(n) == pcs_pkg::REG_TYPES)
				type_codes = data;
			else
				size_log2[n] = data[4:0];
		end
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Hold until every queued item went in and every response came back
	task automatic drain();
		do
			@(negedge clk);
		while (pending_accesses.size() != 0 || req_valid || predicted_responses.size() != 0);
	endtask

	// Request driver: present queued items, idling in random bursts between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			gap_left = 0;
		end else begin
			// Predict at the handshake so the mirror follows acceptance order
			if (req_valid && req_ready)
				predicted_responses.push_back(predict_response(req));
			if (!req_valid || req_ready) begin
				if (gap_left != 0) begin
					req_valid <= 1'b0;
					gap_left--;
				end else if (pending_accesses.size() != 0) begin
					req_valid <= 1'b1;
					req       <= pending_accesses.pop_front();
					if (!quiet && $urandom_range(5) == 0)
						gap_left = $urandom_range(1, 7);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: check each accepted response, stall in random bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (predicted_responses.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: response with nothing outstanding: remap %0d stored %0d",
							$realtime, rsp.remap_needed, rsp.bytes_stored);
				end else begin
					oldest = predicted_responses.pop_front();
					if (rsp.remap_needed !== oldest.remap_needed ||
							rsp.bytes_stored !== oldest.bytes_stored) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: remap exp %0d got %0d, stored exp %0d got %0d",
								$realtime, oldest.remap_needed, rsp.remap_needed,
								oldest.bytes_stored, rsp.bytes_stored);
					end
				end
			end
			if (stall_left != 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(5) == 0) begin
				rsp_ready <= 1'b0;
				stall_left = $urandom_range(6);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int       n;
		int       phase;
		setting_e kind;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		apply_settings(SET_MIXED);

		// Preload the whole space before anything reads it; start with a type-0 header
		for (n = 0; n < 256; n++)
			queue_preload(8'(n), (8'(n) == HEADER_ADDR) ? 32'h0 : $urandom);
		drain();

		// Directed corners under the mixed setting
		queue_write(8'h10, 32'hffff_ffff, 3'd4);  // unimplemented BAR falls to the byte mask
		queue_write(8'h14, 32'hffff_ffff, 3'd4);
		queue_write(8'h1b, 32'h1234_5678, 3'd4);  // unaligned, largest size
		queue_write(8'h18, 32'hffff_ffff, 3'd4);
		queue_write(8'h1c, 32'h0000_0000, 3'd4);
		queue_write(8'h27, 32'ha5a5_a5a5, 3'd4);  // unaligned, last BAR
		queue_write(8'h20, 32'hffff_ffff, 3'd7);  // count saturates to a full word
		queue_write(8'h30, 32'hffff_ffff, 3'd4);
		queue_write(8'h33, 32'h0000_0001, 3'd5);  // unaligned ROM keeps its enable bit
		queue_write(8'h04, 32'hffff_ffff, 3'd0);  // empty access
		queue_write(8'h04, 32'hffff_ffff, 3'd2);
		queue_write(8'h03, 32'hffff_ffff, 3'd2);
		queue_write(8'h02, 32'hffff_ffff, 3'd2);  // ends just below the command register
		queue_write(8'h06, 32'hffff_ffff, 3'd1);
		queue_write(8'hfe, 32'hffff_ffff, 3'd4);  // runs off the end of the space
		queue_write(8'hff, 32'h1234_5678, 3'd7);
		queue_write(8'h3c, 32'hffff_ffff, 3'd4);
		queue_write(8'h40, 32'h0000_0000, 3'd3);
		queue_preload(HEADER_ADDR, 32'(HEADER_MF));
		queue_write(8'h10, 32'hffff_ffff, 3'd2);  // BAR bytes read-only under type 0
		queue_preload(HEADER_ADDR, 32'h0000_0001);
		queue_write(8'h10, 32'hffff_ffff, 3'd2);  // writable under type 1
		queue_write(8'h38, 32'hffff_ffff, 3'd4);
		queue_write(8'h30, 32'hffff_ffff, 3'd3);
		queue_preload(HEADER_ADDR, 32'h0000_0000);
		drain();

		// Random phases, each under a new setting; the last runs without idling
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0:       kind = SET_MAX;
				1:       kind = SET_ZERO;
				2:       kind = SET_MIN;
				default: kind = SET_RANDOM;
			endcase
			apply_settings(kind);
			quiet = (phase == 5);
			repeat (280) pending_accesses.push_back(random_access());
			drain();
		end

		// Let any stray response show up before the verdict
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && predicted_responses.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
